@@ hdl/log7x7_pkg.sv @@
// Shared types and constants for the 7x7 Laplacian-of-Gaussian edge filter.
// Used by every module in this folder but log7x7_ram; depends on nothing.
`timescale 1ns / 1ps

package log7x7_pkg;

    localparam int PIX_W         = 8;
    localparam int KSIZE         = 7;
    localparam int STORE_ROWS    = KSIZE - 1;
    localparam int CENTRE_OFS    = KSIZE / 2;
    localparam int CFG_W         = 11;
    localparam int COORD_W       = 10;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int LINE_WIDTH_RST = 640;
    localparam int ROW_LIMIT     = 1023;
    localparam int FIFO_DEPTH    = 16;
    localparam int OUT_TDATA_W   = 32;

    // The kernel sum lies in -16320..16320. Adding 50*327 makes it non-negative,
    // so floor(sum/50) + 127 equals floor(u/50) - 200.
    localparam int DIV_BIAS      = 16350;
    localparam int OUT_OFFSET    = 200;
    // floor(v/25) = (v * 20972) >> 19 for every v below 43690.
    localparam int RECIP         = 20972;
    localparam int RECIP_SHIFT   = 19;
    localparam int PIX_MAX       = 255;

    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] window_t;

    typedef struct packed {
        logic [COORD_W-1:0] centre_row;
        logic [COORD_W-1:0] centre_col;
    } coord_t;

    typedef struct packed {
        coord_t             coord;
        logic [PIX_W-1:0]   filtered;
    } result_t;

endpackage

@@ hdl/log7x7_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module log7x7_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/log7x7_line_buf.sv @@
// Line store read-modify-write and the 7x7 pixel window.
// Depends on log7x7_pkg and log7x7_ram.
`timescale 1ns / 1ps

module log7x7_line_buf #(
    parameter int MAX_WIDTH = log7x7_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [log7x7_pkg::PIX_W-1:0]       in_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]       in_col,
    input  logic                               in_emit,
    input  log7x7_pkg::coord_t                 in_coord,
    output log7x7_pkg::window_t                window,
    output logic                               out_valid,
    output log7x7_pkg::coord_t                 out_coord
);

    import log7x7_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int COLV_W = PIX_W * STORE_ROWS;

    // Stage 0: the read is in flight.
    logic                s0_valid_reg;
    logic [PIX_W-1:0]    s0_px_reg;
    logic [COL_W-1:0]    s0_col_reg;
    logic                s0_emit_reg;
    coord_t              s0_coord_reg;

    // Forwarding for back-to-back requests to the same column.
    logic                fwd_reg;
    logic [COLV_W-1:0]   fwd_data_reg;

    logic [COLV_W-1:0]   ram_rdata;
    logic [COLV_W-1:0]   col_data;
    logic [COLV_W-1:0]   wdata;

    window_t             window_reg;
    logic                v1_reg;
    coord_t              coord1_reg;

    // Store slot k holds the pixel from k+1 rows back at this column.
    assign col_data = fwd_reg ? fwd_data_reg : ram_rdata;
    assign wdata    = {col_data[PIX_W*(STORE_ROWS-1)-1:0], s0_px_reg};

    log7x7_ram #(
        .WIDTH (COLV_W),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (s0_valid_reg),
        .waddr (s0_col_reg),
        .wdata (wdata),
        .re    (in_valid),
        .raddr (in_col),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            v1_reg       <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= in_valid;
            v1_reg       <= s0_valid_reg && s0_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s0_px_reg    <= in_pixel;
            s0_col_reg   <= in_col;
            s0_emit_reg  <= in_emit;
            s0_coord_reg <= in_coord;
            fwd_reg      <= s0_valid_reg && (s0_col_reg == in_col);
            fwd_data_reg <= wdata;
        end
        if (s0_valid_reg)
        begin
            for (int r = 0; r < KSIZE; r++)
            begin
                for (int c = 0; c < KSIZE - 1; c++)
                begin
                    window_reg[r][c] <= window_reg[r][c+1];
                end
            end
            // Oldest row at the top, incoming pixel at the bottom.
            for (int r = 0; r < STORE_ROWS; r++)
            begin
                window_reg[r][KSIZE-1] <= col_data[PIX_W*(STORE_ROWS-1-r) +: PIX_W];
            end
            window_reg[KSIZE-1][KSIZE-1] <= s0_px_reg;
            coord1_reg <= s0_coord_reg;
        end
    end

    assign window    = window_reg;
    assign out_valid = v1_reg;
    assign out_coord = coord1_reg;

endmodule

@@ hdl/log7x7_conv.sv @@
// Pipelined constant-kernel convolution, divide by 50 and clamp.
// Depends on log7x7_pkg.
`timescale 1ns / 1ps

module log7x7_conv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  log7x7_pkg::window_t          window,
    input  log7x7_pkg::coord_t           in_coord,
    output logic                         out_valid,
    output log7x7_pkg::result_t          out_result
);

    import log7x7_pkg::*;

    localparam int S2_W   = PIX_W + 1;
    localparam int S4_W   = PIX_W + 2;
    localparam int S8_W   = PIX_W + 3;
    localparam int ACC_W  = PIX_W + 6;
    localparam int U_W    = ACC_W + 1;
    localparam int H_W    = U_W - 1;
    localparam int PROD_W = H_W + U_W;
    localparam int Q_W    = PROD_W - RECIP_SHIFT;
    localparam int NSTG   = 6;

    function automatic logic [S4_W-1:0] add4(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] d
    );
        add4 = S4_W'(a) + S4_W'(b) + S4_W'(c) + S4_W'(d);
    endfunction

    function automatic logic [S2_W-1:0] add2(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b
    );
        add2 = S2_W'(a) + S2_W'(b);
    endfunction

    logic [NSTG-1:0] vld_reg;
    coord_t          crd_reg [NSTG];

    // Stage 1: half sums of each equal-coefficient group.
    logic [S4_W-1:0]  m1a_reg, m1b_reg, m2a_reg, m2b_reg, m3a_reg, m3b_reg;
    logic [S2_W-1:0]  m4a_reg, m4b_reg, p1a_reg, p1b_reg, p9a_reg, p9b_reg;
    logic [PIX_W-1:0] p24_reg;
    // Stage 2: group sums.
    logic [S8_W-1:0]  m1_reg, m2_reg, m3_reg;
    logic [S4_W-1:0]  m4_reg, p1_reg, p9_reg;
    logic [PIX_W-1:0] c24_reg;
    // Stage 3: positive and negative halves of the kernel sum.
    logic [ACC_W-1:0] pos_reg, neg_reg;
    // Stage 4: biased sum, always non-negative.
    logic [U_W-1:0]   u_reg;
    // Stage 5: reciprocal product.
    logic [PROD_W-1:0] prod_reg;
    // Stage 6: clamped response.
    logic [PIX_W-1:0] filt_reg;

    logic [Q_W-1:0]   quot;
    logic [PIX_W-1:0] filt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        crd_reg[0] <= in_coord;
        for (int i = 1; i < NSTG; i++)
        begin
            crd_reg[i] <= crd_reg[i-1];
        end

        m1a_reg <= add4(window[0][2], window[0][4], window[6][2], window[6][4]);
        m1b_reg <= add4(window[2][0], window[2][6], window[4][0], window[4][6]);
        m2a_reg <= add4(window[0][3], window[6][3], window[1][1], window[1][5]);
        m2b_reg <= add4(window[5][1], window[5][5], window[3][0], window[3][6]);
        m3a_reg <= add4(window[1][2], window[1][4], window[5][2], window[5][4]);
        m3b_reg <= add4(window[2][1], window[2][5], window[4][1], window[4][5]);
        m4a_reg <= add2(window[1][3], window[5][3]);
        m4b_reg <= add2(window[3][1], window[3][5]);
        p1a_reg <= add2(window[2][2], window[2][4]);
        p1b_reg <= add2(window[4][2], window[4][4]);
        p9a_reg <= add2(window[2][3], window[4][3]);
        p9b_reg <= add2(window[3][2], window[3][4]);
        p24_reg <= window[3][3];

        m1_reg  <= S8_W'(m1a_reg) + S8_W'(m1b_reg);
        m2_reg  <= S8_W'(m2a_reg) + S8_W'(m2b_reg);
        m3_reg  <= S8_W'(m3a_reg) + S8_W'(m3b_reg);
        m4_reg  <= S4_W'(m4a_reg) + S4_W'(m4b_reg);
        p1_reg  <= S4_W'(p1a_reg) + S4_W'(p1b_reg);
        p9_reg  <= S4_W'(p9a_reg) + S4_W'(p9b_reg);
        c24_reg <= p24_reg;

        // 9x = 8x + x, 24x = 16x + 8x, 3x = 2x + x.
        pos_reg <= ACC_W'(p1_reg) + (ACC_W'(p9_reg) << 3) + ACC_W'(p9_reg)
                 + (ACC_W'(c24_reg) << 4) + (ACC_W'(c24_reg) << 3);
        neg_reg <= ACC_W'(m1_reg) + (ACC_W'(m2_reg) << 1) + (ACC_W'(m3_reg) << 1)
                 + ACC_W'(m3_reg) + (ACC_W'(m4_reg) << 2);

        u_reg    <= U_W'(pos_reg) + U_W'(DIV_BIAS) - U_W'(neg_reg);
        // floor(u/50) = floor(floor(u/2)/25).
        prod_reg <= PROD_W'(u_reg[U_W-1:1]) * PROD_W'(RECIP);
        filt_reg <= filt_next;
    end

    assign quot = prod_reg[PROD_W-1:RECIP_SHIFT];

    always_comb
    begin
        priority if (quot < Q_W'(OUT_OFFSET))
        begin
            filt_next = '0;
        end
        else if (quot > Q_W'(OUT_OFFSET + PIX_MAX))
        begin
            filt_next = PIX_W'(PIX_MAX);
        end
        else
        begin
            filt_next = PIX_W'(quot - Q_W'(OUT_OFFSET));
        end
    end

    assign out_valid           = vld_reg[NSTG-1];
    assign out_result.filtered = filt_reg;
    assign out_result.coord    = crd_reg[NSTG-1];

endmodule

@@ hdl/log7x7_out_fifo.sv @@
// Result queue between the convolution pipeline and the output stream.
// Depends on log7x7_pkg; the caller keeps it from overflowing.
`timescale 1ns / 1ps

module log7x7_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  log7x7_pkg::result_t  in_result,
    output logic                 out_valid,
    input  logic                 out_ready,
    output log7x7_pkg::result_t  out_result
);

    import log7x7_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t          mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && out_ready;
    assign out_result = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (in_valid)
        begin
            count_next = count_next + CNT_W'(1);
        end
        if (pop)
        begin
            count_next = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            mem_reg[wr_ptr_reg] <= in_result;
        end
    end

endmodule

@@ hdl/log_7x7_edge_filter.sv @@
// Top level of the streaming 7x7 Laplacian-of-Gaussian edge filter.
// Depends on log7x7_pkg, log7x7_line_buf, log7x7_conv and log7x7_out_fifo.
//
//  Channel   Direction  Signals                       Contents
//  s_*       in         s_tvalid s_tready s_tdata     tdata[7:0] pixel
//                       s_tuser                       tuser frame_start
//  m_*       out        m_tvalid m_tready m_tdata     [7:0] filtered, [17:8] centre_col,
//                                                     [27:18] centre_row, [31:28] zero
//  cfg_*     in         cfg_valid cfg_ready cfg_data  line_width (11 bits)
//
// One pixel request is taken per clock while s_tready is high. The result for the
// pixel that completes its window passes the store read, the window update, six
// convolution stages and the queue write before it shows on m_tdata. While sixteen
// results wait, s_tready is low. Reset clears the counters and sets line_width to
// 640; the line store is not cleared, as no result reads an entry this frame has
// not written. cfg_ready is always high.
`timescale 1ns / 1ps

module log_7x7_edge_filter #(
    parameter int MAX_WIDTH = log7x7_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [log7x7_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel
    input  logic                               s_tuser,   // [0] frame_start
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] filtered, [17:8] centre_col, [27:18] centre_row, [31:28] zero
    output logic [log7x7_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [log7x7_pkg::CFG_W-1:0]       cfg_data
);

    import log7x7_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WW     = ((COL_W + 1) > CFG_W) ? (COL_W + 1) : CFG_W;
    localparam int PEND_W = $clog2(FIFO_DEPTH) + 1;

    logic [CFG_W-1:0]   line_width_reg;
    logic [COL_W-1:0]   col_cnt_reg;
    logic [COL_W-1:0]   col_cnt_next;
    logic [COORD_W-1:0] row_cnt_reg;
    logic [COORD_W-1:0] row_cnt_next;
    logic [PEND_W-1:0]  pending_reg;
    logic [PEND_W-1:0]  pending_next;

    logic               accept;
    logic [WW-1:0]      wide_width;
    logic [COL_W-1:0]   col_last;
    logic [COL_W-1:0]   col_cur;
    logic [COORD_W-1:0] row_cur;
    logic [COL_W-1:0]   col_diff;
    logic               emit;
    coord_t             coord_in;

    window_t            window;
    logic               win_valid;
    coord_t             win_coord;
    logic               conv_valid;
    result_t            conv_result;
    result_t            out_result;
    logic               out_pop;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign out_pop   = m_tvalid && m_tready;

    // Every pending result has a reserved queue slot, so the queue never overflows.
    assign s_tready  = (pending_reg < PEND_W'(FIFO_DEPTH));

    // Effective width is line_width held within 7..MAX_WIDTH; col_last is its last column.
    assign wide_width = WW'(line_width_reg);

    always_comb
    begin
        priority if (wide_width < WW'(KSIZE))
        begin
            col_last = COL_W'(KSIZE - 1);
        end
        else if (wide_width > WW'(MAX_WIDTH))
        begin
            col_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last = COL_W'(wide_width - WW'(1));
        end
    end

    // A frame start puts this pixel at row 0, column 0.
    assign col_cur = s_tuser ? '0 : col_cnt_reg;
    assign row_cur = s_tuser ? '0 : row_cnt_reg;

    // A result exists once the window lies wholly inside the frame.
    assign emit     = (col_cur >= COL_W'(KSIZE - 1)) && (row_cur >= COORD_W'(KSIZE - 1));
    assign col_diff = col_cur - COL_W'(CENTRE_OFS);
    assign coord_in.centre_col = COORD_W'(col_diff);
    assign coord_in.centre_row = row_cur - COORD_W'(CENTRE_OFS);

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            if (col_cur >= col_last)
            begin
                col_cnt_next = '0;
                row_cnt_next = (row_cur < COORD_W'(ROW_LIMIT)) ?
                               row_cur + COORD_W'(1) : row_cur;
            end
            else
            begin
                col_cnt_next = col_cur + COL_W'(1);
                row_cnt_next = row_cur;
            end
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        if (accept && emit)
        begin
            pending_next = pending_next + PEND_W'(1);
        end
        if (out_pop)
        begin
            pending_next = pending_next - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= CFG_W'(LINE_WIDTH_RST);
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            pending_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                line_width_reg <= cfg_data;
            end
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            pending_reg <= pending_next;
        end
    end

    log7x7_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_pixel  (s_tdata),
        .in_col    (col_cur),
        .in_emit   (emit),
        .in_coord  (coord_in),
        .window    (window),
        .out_valid (win_valid),
        .out_coord (win_coord)
    );

    log7x7_conv u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (win_valid),
        .window     (window),
        .in_coord   (win_coord),
        .out_valid  (conv_valid),
        .out_result (conv_result)
    );

    log7x7_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (conv_valid),
        .in_result  (conv_result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {(OUT_TDATA_W - 2 * COORD_W - PIX_W)'(0),
                      out_result.coord.centre_row,
                      out_result.coord.centre_col,
                      out_result.filtered};

endmodule

@@ tb/log7x7_response_check.sv @@
// Watches the pixel, result and width channels of the 7x7 LoG edge filter.
// It predicts every result, compares them in order, and counts mismatches.
// Depends on log7x7_pkg.
`timescale 1ns / 1ps

module log7x7_response_check (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [log7x7_pkg::PIX_W-1:0]       s_tdata,
    input  logic                               s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [log7x7_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [log7x7_pkg::CFG_W-1:0]       cfg_data,
    output int                                 fail_count,
    output int                                 pending
);
    import log7x7_pkg::*;

    localparam int MAX_W      = MAX_WIDTH_DEF;

    logic [CFG_W-1:0] width_reg;
    logic [PIX_W-1:0] rows_held [STORE_ROWS][MAX_W];
    logic [PIX_W-1:0] win [KSIZE][KSIZE];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    result_t          expected_q [$];

    // The kernel is symmetric in both axes, so one quadrant is enough.
    function automatic int kernel_tap(input int r, input int c);
        int rr;
        int cc;
        rr = (r > CENTRE_OFS) ? KSIZE - 1 - r : r;
        cc = (c > CENTRE_OFS) ? KSIZE - 1 - c : c;
        case (rr * 4 + cc)
            2, 8:   return -1;
            3, 5,
            12:     return -2;
            6, 9:   return -3;
            7, 13:  return -4;
            10:     return 1;
            11, 14: return 9;
            15:     return 24;
            default: return 0;
        endcase
    endfunction

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic take_pixel(input logic [PIX_W-1:0] px, input logic restart);
        logic [PIX_W-1:0] slice [KSIZE];
        int unsigned      w;
        int unsigned      col;
        int unsigned      cc;
        int unsigned      rc;
        int               acc;
        int               q;
        int               pv;
        result_t          res;

        w = 32'(width_reg);
        if (w < KSIZE) w = KSIZE;
        if (w > MAX_W) w = MAX_W;
        if (restart)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        col = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;

        // Column slice, oldest row on top and the new pixel at the bottom.
        for (int k = 0; k < STORE_ROWS; k++)
            slice[k] = rows_held[STORE_ROWS - 1 - k][col];
        slice[STORE_ROWS] = px;
        for (int k = STORE_ROWS - 1; k > 0; k--)
            rows_held[k][col] = rows_held[k - 1][col];
        rows_held[0][col] = px;

        for (int r = 0; r < KSIZE; r++)
        begin
            for (int c = 0; c < KSIZE - 1; c++)
                win[r][c] = win[r][c + 1];
            win[r][KSIZE - 1] = slice[r];
        end

        if (col >= KSIZE - 1 && row_cnt >= KSIZE - 1)
        begin
            acc = 0;
            for (int r = 0; r < KSIZE; r++)
                for (int c = 0; c < KSIZE; c++)
                begin
                    pv  = 32'(win[r][c]);
                    acc = acc + kernel_tap(r, c) * pv;
                end
            q = acc / 50;
            if (acc < 0 && q * 50 != acc) q = q - 1;
            q = q + 127;
            if (q < 0) q = 0;
            if (q > PIX_MAX) q = PIX_MAX;
            cc = col - CENTRE_OFS;
            rc = row_cnt - CENTRE_OFS;
            res.filtered         = q[PIX_W-1:0];
            res.coord.centre_col = cc[COORD_W-1:0];
            res.coord.centre_row = rc[COORD_W-1:0];
            expected_q.push_back(res);
        end

        if (col >= w - 1)
        begin
            col_cnt = 0;
            if (row_cnt < ROW_LIMIT) row_cnt++;
        end
        else
        begin
            col_cnt = col + 1;
        end
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
        result_t got;
        result_t want;

        got = word[$bits(result_t)-1:0];
        if (expected_q.size() == 0)
        begin
            report("unexpected result", word, 0);
            return;
        end
        want = expected_q.pop_front();
        if (got.filtered !== want.filtered)
            report("filtered", 32'(got.filtered), 32'(want.filtered));
        if (got.coord.centre_col !== want.coord.centre_col)
            report("centre_col", 32'(got.coord.centre_col), 32'(want.coord.centre_col));
        if (got.coord.centre_row !== want.coord.centre_row)
            report("centre_row", 32'(got.coord.centre_row), 32'(want.coord.centre_row));
        if (word[OUT_TDATA_W-1:$bits(result_t)] !== '0)
            report("pad bits", 32'(word[OUT_TDATA_W-1:$bits(result_t)]), 0);
    endtask

    // Results are compared before the new pixel is predicted, so a result
    // can never be matched against an expectation made at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = CFG_W'(LINE_WIDTH_RST);
            col_cnt    = 0;
            row_cnt    = 0;
            fail_count = 0;
            for (int r = 0; r < KSIZE; r++)
                for (int c = 0; c < KSIZE; c++)
                    win[r][c] = '0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (cfg_valid && cfg_ready) width_reg = cfg_data;
            if (s_tvalid && s_tready) take_pixel(s_tdata, s_tuser);
            pending <= expected_q.size();
        end
    end

endmodule

@@ tb/tb_log_7x7_edge_filter.sv @@
// Stimulus and verdict for the 7x7 Laplacian-of-Gaussian edge filter.
// Depends on log7x7_pkg, log_7x7_edge_filter and log7x7_response_check.
`timescale 1ns / 1ps

module tb_log_7x7_edge_filter;
    import log7x7_pkg::*;

    // The slowest correct run (every request and every result waiting out the
    // longest gap) stays well under this limit.
    localparam int CYCLE_LIMIT  = 3_000_000;
    // This covers the path from a pixel to its result with margin.
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_GAP      = 19;
    // The directed part sends a little over 400 pixels; this tops the run up
    // to roughly 650.
    localparam int RANDOM_ITEMS = 220;

    // Hand-made frame patterns for the directed part.
    localparam int PAT_BRIGHT_CENTRE = 0;
    localparam int PAT_DARK_CENTRE   = 1;
    localparam int PAT_FLAT          = 2;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data  = '0;

    int          fail_count;
    int          pending;
    int unsigned cycles       = 0;
    int unsigned random_sent  = 0;
    int unsigned out_hold     = 0;
    int unsigned out_stall;
    bit          calm_in      = 1'b0;
    bit          calm_out     = 1'b0;

    log_7x7_edge_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    log7x7_response_check u_response_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side back-pressure. After each accepted result the receiver
    // holds m_tready low for a drawn number of cycles. A calm stretch, which
    // toggles now and then, keeps it high so results can stream back to back.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_hold <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
            out_stall = calm_out ? 0 : $urandom_range(0, MAX_GAP);
            out_hold <= out_stall;
            m_tready <= (out_stall == 0);
        end
        else if (out_hold != 0)
        begin
            out_hold <= out_hold - 1;
            m_tready <= (out_hold == 1);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Sends one pixel request. s_tvalid stays high after acceptance; the next
    // call either replaces the data in the same step or lowers it for a gap,
    // so each step holds at most one assignment to it.
    task automatic push_pixel(input logic [PIX_W-1:0] px, input logic restart);
        int unsigned gap;

        if ($urandom_range(0, 31) == 0) calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= restart;
        do @(posedge clk); while (!s_tready);
    endtask

    // Stops sending and waits until every predicted result has come out, plus
    // the pipeline latency, since the last pixels may have caused none.
    // The first edge lets the checker's pending count catch up with the last
    // accepted request.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Width writes happen only with the filter idle.
    task automatic set_width(input logic [CFG_W-1:0] value);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One 7x7 frame at width 7, which yields exactly one result. The centre
    // 3x3 block carries all the positive taps, so a bright centre saturates
    // high, a dark centre saturates low, and a flat frame outputs 127.
    task automatic pattern_frame(input int pattern);
        logic [PIX_W-1:0] level;
        logic [PIX_W-1:0] px;
        bit               centre;

        level = PIX_W'($urandom_range(0, PIX_MAX));
        for (int r = 0; r < KSIZE; r++)
            for (int c = 0; c < KSIZE; c++)
            begin
                centre = (r >= 2 && r <= 4 && c >= 2 && c <= 4);
                case (pattern)
                    PAT_BRIGHT_CENTRE: px = centre ? PIX_W'(PIX_MAX) : '0;
                    PAT_DARK_CENTRE:   px = centre ? '0 : PIX_W'(PIX_MAX);
                    default:           px = level;
                endcase
                push_pixel(px, r == 0 && c == 0);
            end
    endtask

    // A frame of random pixels, opened with frame_start.
    task automatic noise_frame(input int unsigned cols, input int unsigned rows);
        for (int unsigned i = 0; i < cols * rows; i++)
            push_pixel(PIX_W'($urandom_range(0, PIX_MAX)), i == 0);
    endtask

    initial
    begin
        int unsigned w_cfg;
        int unsigned eff;
        int unsigned total;
        int unsigned shrink_at;
        bit          restart;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Width 0 is below the minimum and acts as 7.
        set_width(CFG_W'(0));
        pattern_frame(PAT_BRIGHT_CENTRE);
        pattern_frame(PAT_DARK_CENTRE);
        pattern_frame(PAT_FLAT);

        // Width shrinks in the middle of a row: the row in progress ends at
        // once and the column wraps. Then a frame restart in mid-frame.
        set_width(CFG_W'(20));
        noise_frame(20, 7);
        for (int i = 0; i < 15; i++)
            push_pixel(PIX_W'($urandom_range(0, PIX_MAX)), 1'b0);
        set_width(CFG_W'(9));
        for (int i = 0; i < 18; i++)
            push_pixel(PIX_W'($urandom_range(0, PIX_MAX)), 1'b0);
        noise_frame(9, 7);

        // All-ones width is above the maximum and acts as 1024: a short run
        // at that width must not wrap the column early.
        set_width(CFG_W'(2047));
        noise_frame(40, 1);

        // Random part: mostly well-formed narrow frames with random content,
        // some cut short, some restarted in mid-frame, some with the width
        // shrunk part way through.
        while (random_sent < RANDOM_ITEMS)
        begin
            w_cfg = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                                : $urandom_range(0, 16);
            set_width(CFG_W'(w_cfg));
            eff = (w_cfg < KSIZE) ? KSIZE : w_cfg;
            if ($urandom_range(0, 5) == 0)
                total = $urandom_range(1, eff * KSIZE);
            else
                total = eff * $urandom_range(KSIZE, KSIZE + 2);
            shrink_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, total) : 0;
            for (int unsigned i = 0; i < total; i++)
            begin
                // Only shrinking is allowed mid-frame; growing would read
                // line store columns that this frame never wrote.
                if (i == shrink_at && i != 0 && eff > KSIZE)
                begin
                    w_cfg = $urandom_range(0, eff - 1);
                    set_width(CFG_W'(w_cfg));
                    eff = (w_cfg < KSIZE) ? KSIZE : w_cfg;
                end
                restart = (i == 0) || ($urandom_range(0, 99) == 0);
                push_pixel(PIX_W'($urandom_range(0, PIX_MAX)), restart);
                random_sent++;
            end
        end

        wait_drain();
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/log7x7_pkg.sv
hdl/log7x7_ram.sv
hdl/log7x7_line_buf.sv
hdl/log7x7_conv.sv
hdl/log7x7_out_fifo.sv
hdl/log_7x7_edge_filter.sv
tb/log7x7_response_check.sv
tb/tb_log_7x7_edge_filter.sv
